// File: rtl/longest_increasing_subsequence_unit_macros.svh
// assertion macros for the longest increasing subsequence unit checker
// expects a clock named clk and a synchronous active-high reset named rst in scope
`ifndef LONGEST_INCREASING_SUBSEQUENCE_UNIT_MACROS_SVH
`define LONGEST_INCREASING_SUBSEQUENCE_UNIT_MACROS_SVH

// same-cycle implication
`define LIS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lis assertion failed");

// next-cycle implication
`define LIS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lis assertion failed");

`endif

// File: rtl/lis_pkg.sv
// shared types and constants for the longest increasing subsequence unit
// no dependencies; used by controller, datapath and top level
package lis_pkg;

  localparam int MAX_ITEMS = 4096;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int ADDR_W    = $clog2(MAX_ITEMS);
  localparam int VAL_W     = 32;
  localparam int FIELD_W   = 13;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 56;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_CHK_FIRST,
    S_CHK_LAST,
    S_PROBE_RD,
    S_PROBE_CHK,
    S_PRED_RD,
    S_WRITE
  } lis_state_t;

  typedef enum logic [1:0] {
    RD_FIRST,
    RD_LAST,
    RD_MID,
    RD_PRED
  } lis_rd_sel_t;

  typedef enum logic [1:0] {
    SLOT_HOLD,
    SLOT_ONE,
    SLOT_EXTEND,
    SLOT_LO
  } lis_slot_sel_t;

  typedef struct packed {
    logic          load;
    logic          take_item;
    logic          mark_ovf;
    logic          open_first;
    lis_slot_sel_t slot_sel;
    logic          search_init;
    logic          search_step;
    logic          rd_en;
    lis_rd_sel_t   rd_sel;
    logic          emit;
  } lis_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic goes_right;
    logic lo_lt_hi;
    logic out_free;
  } lis_status_t;

endpackage

// File: rtl/lis_controller.sv
// sequencing state machine for the longest increasing subsequence unit
// depends on lis_pkg; drives lis_datapath through command and status structs
module lis_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lis_pkg::lis_status_t status,
  output lis_pkg::lis_cmd_t    cmd
);

  lis_pkg::lis_state_t state;
  lis_pkg::lis_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lis_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      lis_pkg::S_IDLE: begin
        if (in_valid) state_next = lis_pkg::S_DECIDE;
      end
      lis_pkg::S_DECIDE: begin
        if (status.full || status.empty) state_next = lis_pkg::S_WRITE;
        else state_next = lis_pkg::S_CHK_FIRST;
      end
      lis_pkg::S_CHK_FIRST: begin
        if (!status.goes_right) state_next = lis_pkg::S_WRITE;
        else state_next = lis_pkg::S_CHK_LAST;
      end
      lis_pkg::S_CHK_LAST: begin
        if (status.goes_right) state_next = lis_pkg::S_PRED_RD;
        else state_next = lis_pkg::S_PROBE_RD;
      end
      lis_pkg::S_PROBE_RD: begin
        if (status.lo_lt_hi) state_next = lis_pkg::S_PROBE_CHK;
        else state_next = lis_pkg::S_PRED_RD;
      end
      lis_pkg::S_PROBE_CHK: state_next = lis_pkg::S_PROBE_RD;
      lis_pkg::S_PRED_RD:   state_next = lis_pkg::S_WRITE;
      lis_pkg::S_WRITE: begin
        if (status.out_free) state_next = lis_pkg::S_IDLE;
      end
      default: state_next = lis_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.slot_sel = lis_pkg::SLOT_HOLD;
    cmd.rd_sel   = lis_pkg::RD_FIRST;
    in_ready = 1'b0;
    case (state)
      lis_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      lis_pkg::S_DECIDE: begin
        if (status.full) begin
          cmd.mark_ovf = 1'b1;
        end else begin
          cmd.take_item = 1'b1;
          if (status.empty) begin
            cmd.open_first = 1'b1;
            cmd.slot_sel   = lis_pkg::SLOT_ONE;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = lis_pkg::RD_FIRST;
          end
        end
      end
      lis_pkg::S_CHK_FIRST: begin
        if (!status.goes_right) begin
          cmd.slot_sel = lis_pkg::SLOT_ONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = lis_pkg::RD_LAST;
        end
      end
      lis_pkg::S_CHK_LAST: begin
        if (status.goes_right) cmd.slot_sel = lis_pkg::SLOT_EXTEND;
        else cmd.search_init = 1'b1;
      end
      lis_pkg::S_PROBE_RD: begin
        if (status.lo_lt_hi) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = lis_pkg::RD_MID;
        end else begin
          cmd.slot_sel = lis_pkg::SLOT_LO;
        end
      end
      lis_pkg::S_PROBE_CHK: cmd.search_step = 1'b1;
      lis_pkg::S_PRED_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = lis_pkg::RD_PRED;
      end
      lis_pkg::S_WRITE: cmd.emit = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// File: rtl/lis_datapath.sv
// tail memories, search bounds, counters and output register of the unit
// depends on lis_pkg; commanded by lis_controller
module lis_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic                           cfg_data,
  input  logic signed [lis_pkg::VAL_W-1:0] in_value,
  input  logic                           in_start,
  input  logic                           in_last,
  input  lis_pkg::lis_cmd_t              cmd,
  output lis_pkg::lis_status_t           status,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [lis_pkg::FIELD_W-1:0]    out_item_index,
  output logic [lis_pkg::FIELD_W-1:0]    out_run_length,
  output logic [lis_pkg::FIELD_W-1:0]    out_pred_index,
  output logic [lis_pkg::FIELD_W-1:0]    out_longest,
  output logic                           out_done,
  output logic                           out_ovf
);

  localparam int CW = lis_pkg::CNT_W;
  localparam int AW = lis_pkg::ADDR_W;
  localparam int FW = lis_pkg::FIELD_W;

  logic signed [lis_pkg::VAL_W-1:0] tail_values  [lis_pkg::MAX_ITEMS];
  logic [CW-1:0]                    tail_indices [lis_pkg::MAX_ITEMS];

  logic                             allow_equal;
  logic signed [lis_pkg::VAL_W-1:0] value;
  logic                             last;
  logic                             ovf;
  logic [CW-1:0]                    longest;
  logic [CW-1:0]                    count;
  logic [CW-1:0]                    lo;
  logic [CW-1:0]                    hi;
  logic [CW-1:0]                    slot;
  logic signed [lis_pkg::VAL_W-1:0] rd_val;
  logic [CW-1:0]                    rd_idx;

  logic [CW:0]   mid_sum;
  logic [CW-1:0] mid;
  logic [CW-1:0] extend;
  logic [CW-1:0] rd_slot;
  logic [CW-1:0] rd_off;
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] wr_off;
  logic [AW-1:0] wr_addr;
  logic          out_free;

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[CW:1];
  assign extend  = (longest < CW'(lis_pkg::MAX_ITEMS)) ? longest + CW'(1) : longest;

  // read slot, one-based; predecessor lives one slot below the chosen one
  always_comb begin
    case (cmd.rd_sel)
      lis_pkg::RD_FIRST: rd_slot = CW'(1);
      lis_pkg::RD_LAST:  rd_slot = longest;
      lis_pkg::RD_MID:   rd_slot = mid;
      lis_pkg::RD_PRED:  rd_slot = slot - CW'(1);
      default:           rd_slot = CW'(1);
    endcase
  end
  assign rd_off  = rd_slot - CW'(1);
  assign rd_addr = rd_off[AW-1:0];
  assign wr_off  = slot - CW'(1);
  assign wr_addr = wr_off[AW-1:0];

  assign out_free = !out_valid || out_ready;

  always_comb begin
    status.full       = (count >= CW'(lis_pkg::MAX_ITEMS));
    status.empty      = (longest == '0);
    status.goes_right = allow_equal ? (rd_val <= value) : (rd_val < value);
    status.lo_lt_hi   = (lo < hi);
    status.out_free   = out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      allow_equal <= 1'b0;
    end else if (cfg_valid) begin
      allow_equal <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      longest <= '0;
      count   <= '0;
    end else begin
      if (cmd.load && in_start) begin
        longest <= '0;
        count   <= '0;
      end
      if (cmd.take_item) count <= count + CW'(1);
      if (cmd.open_first) longest <= CW'(1);
      if (cmd.slot_sel == lis_pkg::SLOT_EXTEND) longest <= extend;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value <= in_value;
      last  <= in_last;
      ovf   <= 1'b0;
    end
    if (cmd.mark_ovf) ovf <= 1'b1;
    if (cmd.search_init) begin
      lo <= CW'(1);
      hi <= longest;
    end
    if (cmd.search_step) begin
      if (status.goes_right) lo <= mid + CW'(1);
      else hi <= mid;
    end
    case (cmd.slot_sel)
      lis_pkg::SLOT_ONE:    slot <= CW'(1);
      lis_pkg::SLOT_EXTEND: slot <= extend;
      lis_pkg::SLOT_LO:     slot <= lo;
      default:              slot <= slot;
    endcase
  end

  // tail memories: one registered read, one write per cycle
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_val <= tail_values[rd_addr];
      rd_idx <= tail_indices[rd_addr];
    end
    if (cmd.emit && !ovf) begin
      tail_values[wr_addr]  <= value;
      tail_indices[wr_addr] <= count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_item_index <= ovf ? '0 : FW'(count);
      out_run_length <= ovf ? '0 : FW'(slot);
      out_pred_index <= (ovf || slot <= CW'(1)) ? '0 : FW'(rd_idx);
      out_longest    <= FW'(longest);
      out_done       <= last;
      out_ovf        <= ovf;
    end
  end

endmodule

// File: rtl/longest_increasing_subsequence_unit.sv
// longest increasing subsequence unit, patience method with binary search over a tail table
// top level; depends on lis_pkg, lis_controller and lis_datapath
//
// One item (a signed 32-bit sample) is taken at a time; s_tuser marks the first item of a
// sequence and s_tlast its final one. Each item gives one result: its one-based index, the
// length of the best run ending at it, the index of its predecessor in that run (0 if none)
// and the longest length so far, with tlast echoing the input's last mark and tuser set when
// the item was dropped because 4096 items were already taken in this sequence. After
// acceptance a dropped item, or one met by an empty table, goes from the decide state to
// the write state; one that lands in slot one also checks the first tail; one that
// extends the longest run checks both first and last tails and reads its predecessor;
// others binary-search the table, each probe a read then a check state, then read their
// predecessor, write and go idle. The tail memory has a single read port with registered
// data. The result sits in an output register, so the next item is taken while a
// result waits downstream. The tail memory needs no clearing after reset: only slots written
// in the current sequence are ever read. cfg_data sets the order: 0 strictly increasing,
// 1 non-decreasing; write it only while the unit is idle.
module longest_increasing_subsequence_unit (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_data,      // allow_equal
  // input items
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [lis_pkg::IN_TDATA_W-1:0]   s_tdata,       // [31:0] sample_value
  input  logic                             s_tuser,       // [0] start_flag
  input  logic                             s_tlast,       // last_flag
  // result items
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [lis_pkg::OUT_TDATA_W-1:0]  m_tdata,       // [12:0] item_index,
                                                          // [25:13] run_length,
                                                          // [38:26] predecessor_index,
                                                          // [51:39] longest_so_far,
                                                          // [55:52] zero
  output logic                             m_tuser,       // [0] overflow_error
  output logic                             m_tlast        // sequence_done
);

  localparam int FW = lis_pkg::FIELD_W;

  lis_pkg::lis_cmd_t    cmd;
  lis_pkg::lis_status_t status;

  logic [FW-1:0] item_index;
  logic [FW-1:0] run_length;
  logic [FW-1:0] pred_index;
  logic [FW-1:0] longest;

  // config writes are always accepted
  assign cfg_ready = 1'b1;

  lis_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  lis_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_data       (cfg_data),
    .in_value       (s_tdata[lis_pkg::VAL_W-1:0]),
    .in_start       (s_tuser),
    .in_last        (s_tlast),
    .cmd            (cmd),
    .status         (status),
    .out_ready      (m_tready),
    .out_valid      (m_tvalid),
    .out_item_index (item_index),
    .out_run_length (run_length),
    .out_pred_index (pred_index),
    .out_longest    (longest),
    .out_done       (m_tlast),
    .out_ovf        (m_tuser)
  );

  // pack result fields, lowest first, zero pad to whole bytes
  assign m_tdata = {(lis_pkg::OUT_TDATA_W - 4 * FW)'(0), longest, pred_index, run_length,
                    item_index};

endmodule

// File: rtl/lis_checker.sv
// port-level checker for the longest increasing subsequence unit, bound to the top level
// depends on longest_increasing_subsequence_unit_macros.svh
`include "longest_increasing_subsequence_unit_macros.svh"

module lis_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  logic [57:0] out_bus;
  logic [12:0] item_index;
  logic [12:0] run_length;
  logic [12:0] pred_index;
  logic [12:0] longest;
  logic        taken;
  logic        run_ok;
  logic        pred_ok;

  assign out_bus    = {m_tlast, m_tuser, m_tdata};
  assign item_index = m_tdata[12:0];
  assign run_length = m_tdata[25:13];
  assign pred_index = m_tdata[38:26];
  assign longest    = m_tdata[51:39];
  assign taken      = m_tvalid && !m_tuser;
  assign run_ok     = (item_index != 13'd0) && (run_length != 13'd0) && (run_length <= longest);
  assign pred_ok    = (pred_index != 13'd0) && (pred_index < item_index);

  // one item at a time: no item is taken in the cycle after an accept
  `LIS_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)

  // a stalled result holds
  `LIS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(out_bus))

  // a dropped item reports no index, length or predecessor
  `LIS_ASSERT_NOW(a_ovf_zero, m_tvalid && m_tuser, m_tdata[38:0] == 39'd0)

  // a taken item has an index and a run no longer than the longest
  `LIS_ASSERT_NOW(a_run_bound, taken, run_ok)

  // a run longer than one points back to an earlier item
  `LIS_ASSERT_NOW(a_pred_order, taken && (run_length > 13'd1), pred_ok)

endmodule

bind longest_increasing_subsequence_unit lis_checker u_lis_checker (.*);

// File: tb/tb_longest_increasing_subsequence_unit.sv
// self-checking testbench for the longest increasing subsequence unit
// depends on lis_pkg and longest_increasing_subsequence_unit; uses its own tail-table predictor
`timescale 1ns / 100ps

module tb_longest_increasing_subsequence_unit;

  localparam logic [31:0] VAL_MIN = 32'h8000_0000;
  localparam logic [31:0] VAL_MAX = 32'h7FFF_FFFF;
  localparam int unsigned RUN_LIMIT_NS = 10_000_000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned LONG_RUN = 120;

  typedef struct packed {
    logic [12:0] item_index;
    logic [12:0] run_length;
    logic [12:0] pred_index;
    logic [12:0] longest;
    logic        seq_done;
    logic        overflow;
  } lis_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {SEQ_SMALL, SEQ_WIDE, SEQ_RISING, SEQ_FALLING} seq_style_t;

  typedef struct {
    row_kind_t   kind;
    logic [31:0] value;
    bit          first_mark;
    bit          last_mark;
    bit          typed;
    lis_result_t want;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [lis_pkg::IN_TDATA_W-1:0] s_tdata = '0;   // [31:0] sample_value
  logic s_tuser = 1'b0;                  // [0] start_flag
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [lis_pkg::OUT_TDATA_W-1:0] m_tdata;  // index, run, predecessor, longest from bit 0 up
  logic m_tuser;                         // [0] overflow_error
  logic m_tlast;

  // predictor state: tail values and their element indexes per run length
  logic signed [31:0] tail_value [1:lis_pkg::MAX_ITEMS];
  logic [12:0]        tail_index [1:lis_pkg::MAX_ITEMS];
  int unsigned        best_length = 0;
  int unsigned        seen_count = 0;
  bit                 order_nondecr = 1'b0;

  lis_result_t   pending_results [$];
  directed_row_t directed_rows [$];
  int unsigned   fail_count = 0;
  int unsigned   burst_left = 0;
  logic [15:0]   rx_cycle = '0;

  longest_increasing_subsequence_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always #4 clk = ~clk;

  // the sample moves right of tail t in the search, i.e. it cannot replace t
  function automatic bit passes_tail(input logic signed [31:0] t, input logic signed [31:0] v);
    return order_nondecr ? (t <= v) : (t < v);
  endfunction

  // patience step: place one sample in the tail table and report its run
  function automatic lis_result_t place_sample(input logic signed [31:0] v,
                                               input bit first_mark, input bit last_mark);
    lis_result_t r;
    int unsigned slot, lo, hi, mid;
    r = '0;
    r.seq_done = last_mark;
    if (first_mark) begin
      best_length = 0;
      seen_count  = 0;
    end
    // capacity exceeded: item dropped, nothing changes
    if (seen_count >= lis_pkg::MAX_ITEMS) begin
      r.longest  = best_length[12:0];
      r.overflow = 1'b1;
      return r;
    end
    seen_count++;
    if (best_length == 0) begin
      slot = 1;
      best_length = 1;
    end else if (!passes_tail(tail_value[1], v)) begin
      slot = 1;
    end else if (passes_tail(tail_value[best_length], v)) begin
      if (best_length < lis_pkg::MAX_ITEMS) best_length++;
      slot = best_length;
    end else begin
      lo = 1;
      hi = best_length;
      while (lo < hi) begin
        mid = (lo + hi) >> 1;
        if (passes_tail(tail_value[mid], v)) lo = mid + 1;
        else hi = mid;
      end
      slot = lo;
    end
    r.pred_index = (slot > 1) ? tail_index[slot-1] : 13'd0;
    tail_value[slot] = v;
    tail_index[slot] = seen_count[12:0];
    r.item_index = seen_count[12:0];
    r.run_length = slot[12:0];
    r.longest    = best_length[12:0];
    return r;
  endfunction

  // hold the sender off until every outstanding result has come back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_order(input bit nondecr);
    drain_results();
    cfg_data  <= nondecr;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    order_nondecr = nondecr;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // queue the expected result, then offer the item in bursts with random gaps
  task automatic issue_item(input logic [31:0] v, input bit first_mark, input bit last_mark,
                            input bit use_given, input lis_result_t given);
    lis_result_t predicted;
    predicted = place_sample(v, first_mark, last_mark);
    pending_results.push_back(use_given ? given : predicted);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? 48 : $urandom_range(1, 10);
    end
    burst_left--;
    s_tdata  <= v;
    s_tuser  <= first_mark;
    s_tlast  <= last_mark;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic add_cfg(input bit nondecr);
    directed_row_t row;
    row = '{ROW_CFG, {31'd0, nondecr}, 1'b0, 1'b0, 1'b0, '0};
    directed_rows.push_back(row);
  endtask

  task automatic add_checked(input logic [31:0] v, input bit f, input bit l,
                             input int idx, input int run, input int pred, input int longest);
    directed_row_t row;
    row = '{ROW_ITEM, v, f, l, 1'b1, '0};
    row.want.item_index = idx[12:0];
    row.want.run_length = run[12:0];
    row.want.pred_index = pred[12:0];
    row.want.longest    = longest[12:0];
    row.want.seq_done   = l;
    directed_rows.push_back(row);
  endtask

  task automatic add_predicted(input logic [31:0] v, input bit f, input bit l);
    directed_row_t row;
    row = '{ROW_ITEM, v, f, l, 1'b0, '0};
    directed_rows.push_back(row);
  endtask

  // well-formed sequences with random content, some with missing or stray marks
  task automatic random_stream(input int unsigned item_goal);
    int unsigned sent, len, k;
    seq_style_t  style;
    logic [31:0] cur;
    bit          broken, first_mark, last_mark;
    sent = 0;
    while (sent < item_goal) begin
      style  = seq_style_t'($urandom_range(0, 3));
      len    = $urandom_range(1, 40);
      broken = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 3) == 0) cur = $urandom_range(0, 1) ? VAL_MAX - 20 : VAL_MIN + 20;
      else cur = int'($urandom_range(0, 200)) - 100;
      for (k = 0; k < len; k++) begin
        case (style)
          SEQ_SMALL: cur = int'($urandom_range(0, 16)) - 8;   // many equal values
          SEQ_WIDE:  cur = $urandom;
          SEQ_RISING: begin
            if ($urandom_range(0, 5) == 0) cur = cur - $urandom_range(0, 20);
            else cur = cur + $urandom_range(0, 3);
          end
          default: begin
            if ($urandom_range(0, 5) == 0) cur = cur + $urandom_range(0, 20);
            else cur = cur - $urandom_range(0, 3);
          end
        endcase
        first_mark = (k == 0) && !(broken && ($urandom_range(0, 1) == 1));
        last_mark  = (k == len - 1) && !(broken && ($urandom_range(0, 1) == 1));
        if ($urandom_range(0, 29) == 0) first_mark = ($urandom_range(0, 1) == 1);
        if ($urandom_range(0, 29) == 0) last_mark = ($urandom_range(0, 1) == 1);
        if ($urandom_range(0, 99) == 0) drain_results();
        issue_item(cur, first_mark, last_mark, 1'b0, '0);
        sent++;
      end
    end
  endtask

  // receiver: calm stretches, random stalls and a periodic stall pattern
  always @(negedge clk) begin
    rx_cycle <= rx_cycle + 16'd1;
    case (rx_cycle[9:8])
      2'd0:    m_tready <= 1'b1;
      2'd1:    m_tready <= ($urandom_range(0, 3) != 0);
      2'd2:    m_tready <= (rx_cycle[2:0] > 3'd2);
      default: m_tready <= ($urandom_range(0, 1) == 1);
    endcase
  end

  task automatic check_field(input string label, input logic [12:0] want,
                             input logic [12:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0d, actual %0d", $time, label, want, got);
      fail_count++;
    end
  endtask

  // compare every accepted result with the oldest expectation
  always @(posedge clk) begin : result_check
    lis_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected result, tdata %h tuser %b tlast %b",
                 $time, m_tdata, m_tuser, m_tlast);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("item_index", want.item_index, m_tdata[12:0]);
        check_field("run_length", want.run_length, m_tdata[25:13]);
        check_field("predecessor_index", want.pred_index, m_tdata[38:26]);
        check_field("longest_so_far", want.longest, m_tdata[51:39]);
        check_field("sequence_done", {12'd0, want.seq_done}, {12'd0, m_tlast});
        check_field("overflow_error", {12'd0, want.overflow}, {12'd0, m_tuser});
        check_field("tdata pad", 13'd0, {9'd0, m_tdata[55:52]});
      end
    end
  end

  initial begin : stimulus
    logic [31:0] cur;
    int unsigned k;

    // directed part, strict order first
    add_cfg(1'b0);
    add_checked(32'd5, 1'b0, 1'b0, 1, 1, 0, 1);      // empty table, no start since reset
    add_checked(32'd3, 1'b0, 1'b0, 2, 1, 0, 1);      // new smallest tail in slot one
    add_checked(32'd7, 1'b0, 1'b0, 3, 2, 2, 2);      // extends the longest run
    add_predicted(32'd7, 1'b0, 1'b0);                // equal value, strict order
    add_checked(VAL_MIN, 1'b1, 1'b0, 1, 1, 0, 1);
    add_checked(VAL_MAX, 1'b0, 1'b0, 2, 2, 1, 2);
    add_checked(VAL_MIN, 1'b0, 1'b0, 3, 1, 0, 2);    // equal to first tail goes to slot one
    add_predicted(32'hFFFF_FFFF, 1'b0, 1'b0);
    add_predicted(32'd0, 1'b0, 1'b1);
    add_cfg(1'b1);
    add_checked(32'd42, 1'b1, 1'b1, 1, 1, 0, 1);     // one-item sequence
    add_checked(32'd4, 1'b1, 1'b0, 1, 1, 0, 1);
    add_checked(32'd4, 1'b0, 1'b0, 2, 2, 1, 2);      // equal values extend
    add_checked(32'd4, 1'b0, 1'b0, 3, 3, 2, 3);
    add_predicted(32'd2, 1'b0, 1'b0);
    add_predicted(32'd3, 1'b0, 1'b0);
    add_predicted(32'd4, 1'b0, 1'b0);
    add_predicted(VAL_MAX, 1'b0, 1'b0);
    add_predicted(VAL_MAX, 1'b0, 1'b1);
    add_checked(VAL_MIN, 1'b1, 1'b0, 1, 1, 0, 1);
    add_checked(VAL_MIN, 1'b0, 1'b0, 2, 2, 1, 2);
    add_predicted(32'h5555_5555, 1'b0, 1'b0);
    add_predicted(32'hAAAA_AAAA, 1'b0, 1'b1);
    add_cfg(1'b0);
    add_predicted(-32'sd5, 1'b1, 1'b0);
    add_predicted(-32'sd7, 1'b0, 1'b0);
    add_predicted(-32'sd6, 1'b0, 1'b1);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_order(directed_rows[i].value[0]);
      end else begin
        issue_item(directed_rows[i].value, directed_rows[i].first_mark,
                   directed_rows[i].last_mark, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // random sequences, alternating the order setting
    for (k = 0; k < 4; k++) begin
      write_order(k[0]);
      random_stream(100);
    end

    // long run with dips so the binary search goes deep
    write_order(1'b1);
    cur = int'($urandom_range(0, 1000)) - 500;
    for (k = 0; k < LONG_RUN; k++) begin
      if ($urandom_range(0, 3) == 0) begin
        issue_item($urandom, k == 0, k == LONG_RUN - 1, 1'b0, '0);
      end else begin
        cur = cur + $urandom_range(0, 1000);
        issue_item(cur, k == 0, k == LONG_RUN - 1, 1'b0, '0);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("%0t ns: run limit reached, %0d results outstanding",
             $time, pending_results.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/lis_pkg.sv
rtl/lis_controller.sv
rtl/lis_datapath.sv
rtl/longest_increasing_subsequence_unit.sv
rtl/lis_checker.sv
tb/tb_longest_increasing_subsequence_unit.sv
